### src/cbf_pkg.sv
// Shared types, constants and the section header table for the capture block framer.
`timescale 1ns / 1ps
`default_nettype none

package cbf_pkg;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_SECTION = 2'd0,
    KIND_DESC    = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_CLOSE   = 2'd3
  } cbf_kind_t;

  // Result status codes
  localparam logic [1:0] ST_NORMAL   = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  // Commands handed from the front end to the byte sequencer
  typedef enum logic [2:0] {
    CMD_SECTION = 3'd0,
    CMD_DESC    = 3'd1,
    CMD_REJECT  = 3'd2,
    CMD_BYTE    = 3'd3,
    CMD_CLOSE   = 3'd4
  } cbf_cmd_kind_t;

  localparam int unsigned BLK_W = 17;

  localparam logic [31:0]      PKT_BLOCK_TYPE = 32'h0000_0006;
  localparam logic [31:0]      RT_WORD     = 32'h000E_0000; // version, pad, length 14
  localparam logic [31:0]      RT_PRESENT  = 32'h0000_0028;
  localparam logic [31:0]      OPT_SIGNAL  = 32'h0001_8001;
  localparam logic [31:0]      OPT_CHANNEL = 32'h0001_8002;
  localparam logic [15:0]      FREQ_BASE_2G = 16'd2407;
  localparam logic [15:0]      FREQ_BASE_5G = 16'd5000;
  localparam logic [15:0]      FLAGS_2G    = 16'h00A0;
  localparam logic [15:0]      FLAGS_5G    = 16'h0140;
  localparam logic [7:0]       LAST_2G_CHAN = 8'd14;
  localparam logic [BLK_W-1:0] RT_LEN      = 17'd14;
  localparam logic [BLK_W-1:0] BLK_OVERHEAD = 17'd52;
  localparam logic [BLK_W-1:0] SEEN_MAX    = 17'h1FFFF;
  localparam logic [BLK_W-1:0] MAX_BLK_RESET = 17'h1FFFF;

  localparam logic [5:0] SECTION_LAST = 6'd47;
  localparam logic [5:0] DESC_LAST    = 6'd41;
  localparam logic [5:0] CLOSE_LAST   = 6'd23;

  // Section header block followed by the interface description block
  localparam logic [7:0] SECTION_BYTES [48] = '{
    8'h0A, 8'h0D, 8'h0D, 8'h0A, 8'h1C, 8'h00, 8'h00, 8'h00,
    8'h4D, 8'h3C, 8'h2B, 8'h1A, 8'h01, 8'h00, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h1C, 8'h00, 8'h00, 8'h00,
    8'h01, 8'h00, 8'h00, 8'h00, 8'h14, 8'h00, 8'h00, 8'h00,
    8'h7F, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00,
    8'h14, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    cbf_kind_t   kind;
    logic [15:0] packet_length;
    logic signed [7:0] signal_dbm;
    logic [7:0]  channel_number;
    logic [63:0] timestamp_us;
    logic [7:0]  payload_byte;
  } cbf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic [1:0] status;
  } cbf_out_t;

  typedef struct packed {
    cbf_cmd_kind_t    kind;
    logic [63:0]      ts;
    logic [BLK_W-1:0] blk;
    logic [BLK_W-1:0] cap;
    logic [15:0]      freq;
    logic             band_5g;
    logic [7:0]       sig;
    logic [7:0]       chan;
    logic [1:0]       pad;
    logic             mismatch;
    logic [7:0]       data;
  } cbf_cmd_t;

endpackage

`default_nettype wire

### src/cbf_front.sv
// Front end: accepts input items, tracks the open packet and issues commands.
`timescale 1ns / 1ps
`default_nettype none

module cbf_front import cbf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [BLK_W-1:0] cfg_wr_data,
  input  wire logic             accept,
  input  wire cbf_in_t          item,
  output logic                  cmd_push,
  output cbf_cmd_t              cmd
);

  logic             open_r, open_nxt;
  logic [15:0]      declared_r, declared_nxt;
  logic [BLK_W-1:0] seen_r, seen_nxt;
  logic [7:0]       sig_r, sig_nxt;
  logic [7:0]       chan_r, chan_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic [BLK_W-1:0] max_r;

  logic [BLK_W-1:0] cap;
  logic [BLK_W-1:0] blk;
  logic [10:0]      chan_x5;
  logic             band_5g;
  logic [BLK_W-1:0] close_cap;

  always_comb begin
    cap      = {1'b0, item.packet_length} + RT_LEN;
    blk      = BLK_OVERHEAD + ((cap + 17'd3) & ~17'd3);
    chan_x5  = {1'b0, item.channel_number, 2'b00} + {3'b000, item.channel_number};
    band_5g  = item.channel_number > LAST_2G_CHAN;
    close_cap = {1'b0, declared_r} + RT_LEN;
  end

  always_comb begin
    open_nxt     = open_r;
    declared_nxt = declared_r;
    seen_nxt     = seen_r;
    sig_nxt      = sig_r;
    chan_nxt     = chan_r;
    blk_nxt      = blk_r;
    cmd_push     = 1'b0;
    cmd          = '0;
    cmd.kind     = CMD_SECTION;
    if (accept) begin
      unique case (item.kind)
        KIND_SECTION: begin
          cmd_push = 1'b1;
          open_nxt = 1'b0;
        end
        KIND_DESC: begin
          cmd_push = 1'b1;
          if (blk > max_r) begin
            cmd.kind = CMD_REJECT;
            open_nxt = 1'b0;
          end else begin
            cmd.kind    = CMD_DESC;
            cmd.ts      = item.timestamp_us;
            cmd.blk     = blk;
            cmd.cap     = cap;
            cmd.band_5g = band_5g;
            cmd.freq    = {5'd0, chan_x5} + (band_5g ? FREQ_BASE_5G : FREQ_BASE_2G);
            cmd.sig     = $unsigned(item.signal_dbm);
            open_nxt     = 1'b1;
            declared_nxt = item.packet_length;
            seen_nxt     = '0;
            sig_nxt      = $unsigned(item.signal_dbm);
            chan_nxt     = item.channel_number;
            blk_nxt      = blk;
          end
        end
        KIND_PAYLOAD: begin
          if (open_r) begin
            // Forward only up to the declared count; count surplus anyway
            if (seen_r < {1'b0, declared_r}) begin
              cmd_push = 1'b1;
              cmd.kind = CMD_BYTE;
              cmd.data = item.payload_byte;
            end
            if (seen_r != SEEN_MAX) begin
              seen_nxt = seen_r + 1'b1;
            end
          end
        end
        KIND_CLOSE: begin
          if (open_r) begin
            cmd_push     = 1'b1;
            cmd.kind     = CMD_CLOSE;
            cmd.blk      = blk_r;
            cmd.sig      = sig_r;
            cmd.chan     = chan_r;
            cmd.pad      = 2'(-close_cap[1:0]);
            cmd.mismatch = seen_r != {1'b0, declared_r};
            open_nxt     = 1'b0;
          end
        end
        default: begin
          cmd_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r     <= 1'b0;
      declared_r <= '0;
      seen_r     <= '0;
      sig_r      <= '0;
      chan_r     <= '0;
      blk_r      <= '0;
      max_r      <= MAX_BLK_RESET;
    end else begin
      open_r     <= open_nxt;
      declared_r <= declared_nxt;
      seen_r     <= seen_nxt;
      sig_r      <= sig_nxt;
      chan_r     <= chan_nxt;
      blk_r      <= blk_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

### src/cbf_cmd_queue.sv
// Short command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
`default_nettype none

module cbf_cmd_queue import cbf_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_en,
  input  wire cbf_cmd_t wr_cmd,
  output logic          full,
  output logic          valid,
  output cbf_cmd_t      rd_cmd,
  input  wire logic     rd_en
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cbf_cmd_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full   = count_r == CNT_FULL;
  assign valid  = count_r != '0;
  assign rd_cmd = slot_r[rd_ptr_r];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/cbf_back.sv
// Byte sequencer: expands each command into output bytes, one per cycle while the output register is free or popped.
`timescale 1ns / 1ps
`default_nettype none

module cbf_back import cbf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire cbf_cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  output cbf_out_t      out_data,
  input  wire logic     out_pop
);

  cbf_cmd_t   cur_r;
  logic       busy_r;
  logic [5:0] idx_r;
  logic       valid_r;
  cbf_out_t   out_r;

  logic       adv;
  logic [5:0] last_idx;
  logic       is_last;
  logic [7:0] byte_val;
  logic [1:0] status;
  logic [31:0] word;
  logic [4:0] tail_idx;

  assign adv = busy_r && (!valid_r || out_pop);

  always_comb begin
    tail_idx = 5'(idx_r - {4'd0, cur_r.pad});
    word     = '0;
    byte_val = '0;
    status   = ST_NORMAL;
    last_idx = '0;
    case (cur_r.kind)
      CMD_SECTION: begin
        last_idx = SECTION_LAST;
        byte_val = SECTION_BYTES[idx_r];
      end
      CMD_DESC: begin
        last_idx = DESC_LAST;
        case (idx_r[5:2])
          4'd0:    word = PKT_BLOCK_TYPE;
          4'd1:    word = {15'd0, cur_r.blk};
          4'd3:    word = cur_r.ts[63:32];
          4'd4:    word = cur_r.ts[31:0];
          4'd5:    word = {15'd0, cur_r.cap};
          4'd6:    word = {15'd0, cur_r.cap};
          4'd7:    word = RT_WORD;
          4'd8:    word = RT_PRESENT;
          4'd9:    word = {cur_r.band_5g ? FLAGS_5G : FLAGS_2G, cur_r.freq};
          4'd10:   word = {24'd0, cur_r.sig};
          default: word = '0;
        endcase
        byte_val = word[{idx_r[1:0], 3'b000} +: 8];
      end
      CMD_REJECT: begin
        status = ST_REJECTED;
      end
      CMD_BYTE: begin
        byte_val = cur_r.data;
      end
      CMD_CLOSE: begin
        last_idx = 6'(cur_r.pad) + CLOSE_LAST;
        status   = cur_r.mismatch ? ST_MISMATCH : ST_NORMAL;
        // Zero padding first, then the option words and trailing length
        case (tail_idx[4:2])
          3'd0:    word = OPT_SIGNAL;
          3'd1:    word = {24'd0, cur_r.sig};
          3'd2:    word = OPT_CHANNEL;
          3'd3:    word = {24'd0, cur_r.chan};
          3'd5:    word = {15'd0, cur_r.blk};
          default: word = '0;
        endcase
        byte_val = (idx_r < {4'd0, cur_r.pad}) ? 8'h00 : word[{tail_idx[1:0], 3'b000} +: 8];
      end
      default: begin
        byte_val = '0;
      end
    endcase
    is_last = idx_r == last_idx;
  end

  // Load the next command when idle or while the last byte of this one leaves
  assign q_pop = q_valid && (!busy_r || (adv && is_last));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
    if (adv) begin
      out_r.out_byte <= byte_val;
      out_r.run_last <= is_last;
      out_r.status   <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (adv) begin
        valid_r <= 1'b1;
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
      if (!busy_r) begin
        busy_r <= q_valid;
        idx_r  <= '0;
      end else if (adv) begin
        if (is_last) begin
          busy_r <= q_valid;
          idx_r  <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  assign out_valid = valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### src/capture_block_framer.sv
// Top level of the capture block framer: front end, command queue and byte sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Turns captured radio packets into a little-endian capture-file byte stream, one byte
// per result transfer. Input items are taken one per cycle whenever full is low: the
// front end classifies each item, keeps the open-packet state and drops a short
// command into a QUEUE_DEPTH-entry queue in the same cycle. The sequencer behind the
// queue emits one byte per cycle into a single output register while pop keeps it
// free, so a payload stream passes at one byte per cycle end to end. Header runs have
// 48 bytes for a section header, 42 for a packet descriptor, 24 to 27 for a close
// (zero padding plus the option words and trailing length) and one for a rejected
// packet; while such a run drains, full rises once the queue fills. An item's command
// goes through a queue slot and cur_r before its byte reaches the output register.
// Payload bytes with no packet open, surplus bytes past the declared length and a
// close with no packet open produce nothing. The max_block_bytes register is written
// through cfg_wr_en/cfg_wr_data and should be changed only while the block is idle.

module capture_block_framer import cbf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire cbf_in_t          in_data,
  output logic                  empty,
  input  wire logic             pop,
  output cbf_out_t              out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [BLK_W-1:0] cfg_wr_data
);

  logic     accept;
  logic     cmd_push;
  cbf_cmd_t cmd;
  logic     q_full;
  logic     q_valid;
  cbf_cmd_t q_cmd;
  logic     q_pop;
  logic     out_valid;

  // A transfer in needs only a free queue slot
  assign full   = q_full;
  assign accept = push && !q_full;
  assign empty  = !out_valid;

  cbf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .item        (in_data),
    .cmd_push    (cmd_push),
    .cmd         (cmd)
  );

  cbf_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_cmd (cmd),
    .full   (q_full),
    .valid  (q_valid),
    .rd_cmd (q_cmd),
    .rd_en  (q_pop)
  );

  // Drain commands into the output register; pop frees it for the next byte
  cbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_pop   (pop)
  );

  // A rejected packet is always a single zero byte closing its run
  a_reject_single : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status == ST_REJECTED) |-> (out_data.run_last && out_data.out_byte == 8'h00))
    else $error("rejected result is not a lone zero byte");

  // A section header transfer always leaves a command waiting in the queue
  a_section_queued : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n && accept && in_data.kind == KIND_SECTION) |-> q_valid)
    else $error("section header command lost");

endmodule

`default_nettype wire
